/* sv/pidl_pkg.sv */
package pidl_pkg;

  // Operation codes of an input item
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_AT    = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_END   = 3'd3;
  localparam logic [2:0] OP_REM_AT    = 3'd4;

  // Status codes of a result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Cell move codes
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_ROT  = 2'd3;

  // Cell index width, enough for the largest supported depth of 64
  localparam int IDXW = 6;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IDXW-1:0] pos;   // 0-based insert/remove place
    logic [IDXW-1:0] tail;  // index of the last list entry (for rotate)
  } pidl_ctl_t;

endpackage

/* sv/pidl_cell.sv */
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  pidl_ctl_t          ctl,
  input  logic signed [31:0] ins_value,
  input  logic signed [31:0] left_data,   // neighbor below (k-1)
  input  logic signed [31:0] right_data,  // neighbor above (k+1)
  input  logic signed [31:0] head_data,   // cell 0, wraps in on rotate
  output logic signed [31:0] data
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // Pick the next entry from self, a neighbor, the insert value or cell 0
  always_comb begin
    data_nxt = data_r;
    case (ctl.mode)
      MODE_INS: begin
        if (MY_IDX == ctl.pos) data_nxt = ins_value;
        else if (MY_IDX > ctl.pos) data_nxt = left_data;
      end
      MODE_DEL: begin
        if (MY_IDX >= ctl.pos) data_nxt = right_data;
      end
      MODE_ROT: begin
        if (MY_IDX == ctl.tail) data_nxt = head_data;
        else if (MY_IDX < ctl.tail) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* sv/positional_insert_delete_list_core.sv */
// Results: an accepted item moves the core into its dump state, which registers each
//   result while the output slot is free; the cell chain rotates one entry per result.
//   No new item is taken until the dump of count entries (one if empty) has ended.
// Reset (rst_n low, synchronous): list empty, no result pending, input ready.
// Cell contents are not reset; only entries below count are ever shown.
module positional_insert_delete_list_core
  import pidl_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation[2:0], position[8:3], value[40:9], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], element[33:2], element_valid[34], zero pad
  output logic        out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [39:0]        out_tdata_r, out_tdata_nxt;
  logic               out_tlast_r, out_tlast_nxt;
  pidl_ctl_t          ctl;

  logic [2:0]         in_op;
  logic [5:0]         in_pos;
  logic signed [31:0] in_value;
  logic               in_xfer;
  logic               slot_free;
  logic               is_full, is_empty, pos_bad;
  logic               dump_last;
  logic [CMPW-1:0]    pos_ext, count_ext;
  logic [IDXW-1:0]    pos_idx;

  logic signed [31:0] cell_data [DEPTH];

  assign in_op    = in_tdata[2:0];
  assign in_pos   = in_tdata[8:3];
  assign in_value = in_tdata[40:9];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign pos_ext   = CMPW'(in_pos);
  assign count_ext = CMPW'(count_r);
  assign pos_bad   = (pos_ext == '0) || (pos_ext > count_ext);
  assign pos_idx   = IDXW'(in_pos - 6'd1);
  assign dump_last = (count_r == '0) || (k_r == count_r - CW'(1));

  // Operation decode, chain control and list bookkeeping
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    ctl.mode   = MODE_HOLD;
    ctl.pos    = '0;
    ctl.tail   = IDXW'(count_r - CW'(1));

    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (out_tready) out_tvalid_nxt = 1'b0;

    if (state_r == S_IDLE) begin
      if (in_xfer) begin
        state_nxt  = S_DUMP;
        k_nxt      = '0;
        status_nxt = ST_OK;
        case (in_op)
          OP_INS_FRONT: begin
            if (is_full) status_nxt = ST_FULL;
            else begin
              ctl.mode  = MODE_INS;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_INS_AT: begin
            if (is_full) status_nxt = ST_FULL;
            else if (is_empty) status_nxt = ST_EMPTY;
            else if (pos_bad) status_nxt = ST_RANGE;
            else begin
              ctl.mode  = MODE_INS;
              ctl.pos   = pos_idx;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_REM_FRONT: begin
            if (is_empty) status_nxt = ST_EMPTY;
            else begin
              ctl.mode  = MODE_DEL;
              count_nxt = count_r - CW'(1);
            end
          end
          OP_REM_END: begin
            if (is_empty) status_nxt = ST_EMPTY;
            else count_nxt = count_r - CW'(1);
          end
          OP_REM_AT: begin
            if (is_empty) status_nxt = ST_EMPTY;
            else if (pos_bad) status_nxt = ST_RANGE;
            else begin
              ctl.mode  = MODE_DEL;
              ctl.pos   = pos_idx;
              count_nxt = count_r - CW'(1);
            end
          end
          default: status_nxt = ST_OK;
        endcase
      end
    end else if (slot_free) begin
      // Dump: show cell 0, then rotate the list by one entry if it is not empty
      out_tvalid_nxt = 1'b1;
      out_tlast_nxt  = dump_last;
      out_tdata_nxt  = {5'd0, !is_empty, is_empty ? 32'sd0 : cell_data[0], status_r};
      if (!is_empty) ctl.mode = MODE_ROT;
      k_nxt = k_r + CW'(1);
      if (dump_last) state_nxt = S_IDLE;
    end
  end

  // Chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign right_d = cell_data[g];
    end else begin : g_below
      assign right_d = cell_data[g+1];
    end
    pidl_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef NO_ASSERTIONS
  // The list never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("list count exceeds depth");

  // An empty-list result is always the only one of its dump
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[34] |-> out_tlast)
    else $error("empty result without last");

  // Count holds while a dump is running
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP && $past(state_r == S_DUMP) |-> $stable(count_r))
    else $error("count changed during dump");

  // A dump never runs past count entries
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP && count_r != '0 |-> k_r < count_r)
    else $error("dump index beyond list");
`endif

endmodule
